@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros. Each macro expects clk_i and rst_ni in
// the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that cond never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

@@ rtl/core/ccfc_pkg.sv @@
// ----------------------------------------------------------------------------
// ccfc_pkg
// Types and constants of the command framer and reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ccfc_pkg;

  localparam int unsigned ChipIdW    = 5;
  localparam int unsigned CfgIndexW  = 1;
  localparam int unsigned FrameW     = 56;
  localparam int unsigned FrameLenW  = 6;
  localparam int unsigned ReplyW     = 48;
  localparam int unsigned SeqW       = 3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgChipId    = 1'b0;
  localparam logic [CfgIndexW-1:0] CfgSeqCheckEn = 1'b1;

  // frame lengths in bits
  localparam logic [FrameLenW-1:0] FrameLenPreamble = 6'd10;
  localparam logic [FrameLenW-1:0] FrameLenLong     = 6'd56;
  localparam logic [FrameLenW-1:0] FrameLenRead     = 6'd16;
  localparam logic [FrameLenW-1:0] FrameLenReadNext = 6'd8;

  // expected reply lengths
  localparam logic [5:0] ReplyLenShort = 6'd8;
  localparam logic [5:0] ReplyLenLong  = 6'd48;

  // frame header codes
  localparam logic [2:0] HdrSetId    = 3'b110;
  localparam logic [2:0] HdrWrite    = 3'b111;
  localparam logic [2:0] HdrRead     = 3'b101;
  localparam logic [2:0] HdrReadNext = 3'b100;

  typedef enum logic [2:0] {
    OP_SETID      = 3'd0,
    OP_WRITE      = 3'd1,
    OP_READ       = 3'd2,
    OP_READNEXT   = 3'd3,
    OP_REPLY      = 3'd4,
    OP_TIMEOUT    = 3'd5,
    OP_LINK_RESET = 3'd6
  } opcode_e;

  typedef enum logic [2:0] {
    PEND_NONE     = 3'd0,
    PEND_SETID    = 3'd1,
    PEND_WRITE    = 3'd2,
    PEND_READ     = 3'd3,
    PEND_READNEXT = 3'd4
  } pend_kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TIMEOUT     = 3'd1,
    ST_BAD_LENGTH  = 3'd2,
    ST_BAD_SEQ     = 3'd3,
    ST_BAD_ID      = 3'd4,
    ST_BAD_ADDRESS = 3'd5,
    ST_NOT_PENDING = 3'd6
  } status_e;

  // XOR of the six bytes of a 48-bit frame body
  function automatic logic [7:0] crc_xor6(input logic [47:0] body);
    logic [7:0] c;
    c = 8'h00;
    for (int i = 0; i < 6; i++) begin
      c = c ^ body[8*i +: 8];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/chip_command_framer_checker_core.sv @@
// ----------------------------------------------------------------------------
// chip_command_framer_checker_core
// Command frame builder and reply checker for a chip on a serial link.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one command or reply event
//   per word: set-id, write, read, read-next, reply arrived, timeout, link
//   reset. Output channel (out_valid_o / out_ready_i) delivers result words:
//   either a frame to transmit or a reply status, with last_o on the final
//   result of each input word. Set-id gives two results (10-bit zero
//   preamble, then the 56-bit frame); link reset and unused opcodes give none.
//   Path: a word lands in the input register, then its first result loads
//   into the output register, where out_valid_o rises. Throughput: one word
//   per cycle while the receiver takes results; set-id holds its word until
//   both of its results load, bounded by the single output register.
//   Reset clears the sequence count, the pending command, the configuration
//   and both registers' valid flags. When the receiver stalls, the output
//   register holds its word, the input register fills, and in_ready_o drops
//   until the output register frees up. Configuration (cfg_we_i) must be
//   written by the user only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module chip_command_framer_checker_core
  import ccfc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIndexW-1:0]  cfg_index_i,
  input  wire logic [ChipIdW-1:0]    cfg_wdata_i,
  // input channel
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [2:0]            opcode_i,
  input  wire logic                  ref_mode_i,
  input  wire logic [19:0]           ref_id_i,
  input  wire logic [7:0]            reg_address_i,
  input  wire logic [31:0]           write_value_i,
  input  wire logic [ReplyW-1:0]     reply_bits_i,
  input  wire logic [5:0]            reply_length_i,
  // output channel
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       frame_valid_o,
  output logic [FrameW-1:0]          frame_bits_o,
  output logic [FrameLenW-1:0]       frame_length_o,
  output logic                       status_valid_o,
  output logic [2:0]                 status_o,
  output logic [31:0]                read_value_o,
  output logic                       last_o
);

  // configuration registers
  logic [ChipIdW-1:0] chip_id_q;
  logic               seq_check_en_q;

  // link state
  logic [SeqW-1:0] seq_count_q, seq_count_d;
  pend_kind_e      pend_kind_q, pend_kind_d;
  logic [7:0]      pend_addr_q, pend_addr_d;

  // input register
  logic              a_valid_q;
  logic              a_phase_q;
  logic [2:0]        a_opcode_q;
  logic              a_ref_mode_q;
  logic [19:0]       a_ref_id_q;
  logic [7:0]        a_addr_q;
  logic [31:0]       a_data_q;
  logic [ReplyW-1:0] a_reply_q;
  logic [5:0]        a_reply_len_q;

  // result computed from the input register
  logic                 res_present;
  logic                 res_frame_valid;
  logic [FrameW-1:0]    res_frame_bits;
  logic [FrameLenW-1:0] res_frame_len;
  logic                 res_status_valid;
  status_e              res_status;
  logic [31:0]          res_read_value;
  logic                 res_last;

  logic       out_free;
  logic       res_load;
  logic       a_consume;
  logic       in_accept;
  logic [47:0] setid_body;
  logic [47:0] write_body;
  logic [19:0] efuse_field;
  logic [4:0]  pads_field;
  status_e     reply_status;
  logic [31:0] reply_value;
  logic [2:0]  reply_seq;
  logic [4:0]  reply_id;

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  // The output register frees up when empty or when its word is being taken.
  assign out_free  = !out_valid_o || out_ready_i;
  assign res_load  = a_valid_q && res_present && out_free;
  // Retire the held word once its final result loads; no-result words
  // retire at once. Set-id retires on its second pass.
  assign a_consume = a_valid_q &&
                     (!res_present ||
                      (out_free && (a_opcode_q != OP_SETID || a_phase_q)));
  assign in_ready_o = !a_valid_q || a_consume;
  assign in_accept  = in_valid_i && in_ready_o;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_id_q      <= '0;
      seq_check_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgChipId:     chip_id_q      <= cfg_wdata_i;
        CfgSeqCheckEn: seq_check_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_phase_q <= 1'b0;
    end else begin
      if (in_accept) begin
        a_valid_q <= 1'b1;
      end else if (a_consume) begin
        a_valid_q <= 1'b0;
      end
      // Advance set-id to its frame pass after the preamble loads.
      if (a_consume) begin
        a_phase_q <= 1'b0;
      end else if (res_load) begin
        a_phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_opcode_q    <= opcode_i;
      a_ref_mode_q  <= ref_mode_i;
      a_ref_id_q    <= ref_id_i;
      a_addr_q      <= reg_address_i;
      a_data_q      <= write_value_i;
      a_reply_q     <= reply_bits_i;
      a_reply_len_q <= reply_length_i;
    end
  end

  // --------------------------------------------------------------------------
  // Frame bodies
  // --------------------------------------------------------------------------
  // Mode 0 carries the efuse id, mode 1 the id pads; the unused field is
  // filled with ones.
  assign efuse_field = a_ref_mode_q ? 20'hFFFFF : a_ref_id_q;
  assign pads_field  = a_ref_mode_q ? a_ref_id_q[4:0] : 5'h1F;
  assign setid_body  = {HdrSetId, 5'h1F, 3'b111, chip_id_q, 4'hF,
                        efuse_field, 3'b111, pads_field};
  assign write_body  = {HdrWrite, chip_id_q, a_addr_q, a_data_q};

  // --------------------------------------------------------------------------
  // Reply check: length, then address (read only), then sequence, then id
  // --------------------------------------------------------------------------
  always_comb begin
    reply_value = '0;
    reply_seq   = '0;
    reply_id    = '0;
    if (pend_kind_q == PEND_NONE) begin
      reply_status = ST_NOT_PENDING;
    end else if (pend_kind_q == PEND_SETID || pend_kind_q == PEND_WRITE) begin
      reply_seq = a_reply_q[2:0];
      reply_id  = a_reply_q[7:3];
      priority if (a_reply_len_q != ReplyLenShort) begin
        reply_status = ST_BAD_LENGTH;
      end else if (seq_check_en_q && reply_seq != seq_count_q) begin
        reply_status = ST_BAD_SEQ;
      end else if (reply_id != chip_id_q) begin
        reply_status = ST_BAD_ID;
      end else begin
        reply_status = ST_OK;
      end
    end else begin
      reply_seq = a_reply_q[42:40];
      reply_id  = a_reply_q[47:43];
      priority if (a_reply_len_q != ReplyLenLong) begin
        reply_status = ST_BAD_LENGTH;
      end else if (pend_kind_q == PEND_READ && a_reply_q[39:32] != pend_addr_q) begin
        reply_status = ST_BAD_ADDRESS;
      end else if (seq_check_en_q && reply_seq != seq_count_q) begin
        reply_status = ST_BAD_SEQ;
      end else if (reply_id != chip_id_q) begin
        reply_status = ST_BAD_ID;
      end else begin
        reply_status = ST_OK;
        reply_value  = a_reply_q[31:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result selection
  // --------------------------------------------------------------------------
  always_comb begin
    res_present      = 1'b0;
    res_frame_valid  = 1'b0;
    res_frame_bits   = '0;
    res_frame_len    = '0;
    res_status_valid = 1'b0;
    res_status       = ST_OK;
    res_read_value   = '0;
    res_last         = 1'b1;
    unique case (a_opcode_q)
      OP_SETID: begin
        res_present     = 1'b1;
        res_frame_valid = 1'b1;
        if (!a_phase_q) begin
          // all-zero preamble ahead of the set-id frame
          res_frame_len = FrameLenPreamble;
          res_last      = 1'b0;
        end else begin
          res_frame_bits = {setid_body, crc_xor6(setid_body)};
          res_frame_len  = FrameLenLong;
        end
      end
      OP_WRITE: begin
        res_present     = 1'b1;
        res_frame_valid = 1'b1;
        res_frame_bits  = {write_body, crc_xor6(write_body)};
        res_frame_len   = FrameLenLong;
      end
      OP_READ: begin
        res_present     = 1'b1;
        res_frame_valid = 1'b1;
        res_frame_bits  = {40'h0, HdrRead, chip_id_q, a_addr_q};
        res_frame_len   = FrameLenRead;
      end
      OP_READNEXT: begin
        res_present     = 1'b1;
        res_frame_valid = 1'b1;
        res_frame_bits  = {48'h0, HdrReadNext, chip_id_q};
        res_frame_len   = FrameLenReadNext;
      end
      OP_REPLY: begin
        res_present      = 1'b1;
        res_status_valid = 1'b1;
        res_status       = reply_status;
        res_read_value   = reply_value;
      end
      OP_TIMEOUT: begin
        res_present      = 1'b1;
        res_status_valid = 1'b1;
        res_status       = (pend_kind_q == PEND_NONE) ? ST_NOT_PENDING : ST_TIMEOUT;
      end
      default: ;  // link reset and the unused opcode give no result
    endcase
  end

  // --------------------------------------------------------------------------
  // Link state update, applied when the held word retires
  // --------------------------------------------------------------------------
  always_comb begin
    seq_count_d = seq_count_q;
    pend_kind_d = pend_kind_q;
    pend_addr_d = pend_addr_q;
    if (a_consume) begin
      unique case (a_opcode_q)
        OP_SETID: begin
          seq_count_d = seq_count_q + 3'd1;
          pend_kind_d = PEND_SETID;
          pend_addr_d = '0;
        end
        OP_WRITE: begin
          seq_count_d = seq_count_q + 3'd1;
          pend_kind_d = PEND_WRITE;
          pend_addr_d = a_addr_q;
        end
        OP_READ: begin
          seq_count_d = seq_count_q + 3'd1;
          pend_kind_d = PEND_READ;
          pend_addr_d = a_addr_q;
        end
        OP_READNEXT: begin
          seq_count_d = seq_count_q + 3'd1;
          pend_kind_d = PEND_READNEXT;
          pend_addr_d = '0;
        end
        OP_REPLY, OP_TIMEOUT: begin
          pend_kind_d = PEND_NONE;
        end
        OP_LINK_RESET: begin
          seq_count_d = '0;
          pend_kind_d = PEND_NONE;
          pend_addr_d = '0;
        end
        default: ;  // drop the unused opcode
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_count_q <= '0;
      pend_kind_q <= PEND_NONE;
      pend_addr_q <= '0;
    end else begin
      seq_count_q <= seq_count_d;
      pend_kind_q <= pend_kind_d;
      pend_addr_q <= pend_addr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= res_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      frame_valid_o  <= res_frame_valid;
      frame_bits_o   <= res_frame_bits;
      frame_length_o <= res_frame_len;
      status_valid_o <= res_status_valid;
      status_o       <= res_status;
      read_value_o   <= res_read_value;
      last_o         <= res_last;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/ccfc_checker.sv @@
// ----------------------------------------------------------------------------
// ccfc_checker
// Port-level assertions for the command framer and reply checker.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ccfc_checker
  import ccfc_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire logic                 frame_valid_o,
  input wire logic [FrameW-1:0]    frame_bits_o,
  input wire logic [FrameLenW-1:0] frame_length_o,
  input wire logic                 status_valid_o,
  input wire logic [2:0]           status_o,
  input wire logic [31:0]          read_value_o,
  input wire logic                 last_o
);

  logic              one_kind;
  logic              preamble_ok;
  logic              frame_len_ok;
  logic              stray_data;
  logic              stalled;
  logic [FrameW+3:0] held_bits;

  assign one_kind     = frame_valid_o ^ status_valid_o;
  assign preamble_ok  = frame_valid_o && frame_length_o == FrameLenPreamble &&
                        frame_bits_o == '0;
  assign frame_len_ok = frame_length_o == FrameLenPreamble ||
                        frame_length_o == FrameLenLong ||
                        frame_length_o == FrameLenRead ||
                        frame_length_o == FrameLenReadNext;
  assign stray_data   = read_value_o != '0 && !(status_valid_o && status_o == ST_OK);
  assign stalled      = out_valid_o && !out_ready_i;
  assign held_bits    = {frame_bits_o, status_o, last_o};

  // A result is either a frame or a status, never both or neither.
  `ASSERT_CLK(a_one_kind, out_valid_o |-> one_kind, "result kind not unique")

  // Only the preamble is a non-final result, and it is all zeros.
  `ASSERT_CLK(a_preamble, (out_valid_o && !last_o) |-> preamble_ok, "bad non-final result")

  // Frame lengths come from the fixed set.
  `ASSERT_CLK(a_frame_len, (out_valid_o && frame_valid_o) |-> frame_len_ok, "illegal frame length")

  // Read data shows only on an ok status.
  `ASSERT_NEVER(a_read_value, out_valid_o && stray_data, "read data without ok status")

  // Hold a stalled result.
  `ASSERT_CLK(a_hold, stalled |=> (out_valid_o && $stable(held_bits)), "stalled result changed")

endmodule

bind chip_command_framer_checker_core ccfc_checker u_ccfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_valid_o  (frame_valid_o),
  .frame_bits_o   (frame_bits_o),
  .frame_length_o (frame_length_o),
  .status_valid_o (status_valid_o),
  .status_o       (status_o),
  .read_value_o   (read_value_o),
  .last_o         (last_o)
);

`default_nettype wire
